/* hdl/fra_pkg.sv */
`timescale 1ns / 1ps

package fra_pkg;

    localparam int OP_W      = 16;
    localparam int CMD_W     = 2;
    localparam int PROD_W    = 2 * OP_W;
    localparam int NUM_W     = PROD_W + 1;
    localparam int DEN_W     = PROD_W;
    localparam int K_W       = $clog2(NUM_W + 1);
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int S_TDATA_W = ((4 * OP_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;
    localparam int M_PAD_W   = M_TDATA_W - NUM_W - DEN_W;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    // which product the shared multiplier forms this cycle
    typedef enum logic [1:0] {
        SEL_P0  = 2'd0,
        SEL_P1  = 2'd1,
        SEL_DEN = 2'd2
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     comb;
        logic     gcd_step;
        logic     div_start;
        logic     div_step;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic g_zero;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

/* hdl/fra_ctrl.sv */
`timescale 1ns / 1ps

module fra_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  fra_pkg::status_t status,
    output fra_pkg::cmd_t    cmd
);
    import fra_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_MUL0 = 8'b0000_0010,
        ST_MUL1 = 8'b0000_0100,
        ST_MUL2 = 8'b0000_1000,
        ST_COMB = 8'b0001_0000,
        ST_GCD  = 8'b0010_0000,
        ST_DIV  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.mul_sel = SEL_P0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL0;
                end
            end
            ST_MUL0: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_P0;
                state_next  = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_P1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = SEL_DEN;
                state_next  = ST_COMB;
            end
            ST_COMB: begin
                cmd.comb   = 1'b1;
                state_next = ST_GCD;
            end
            ST_GCD: begin
                if (status.gcd_done) begin
                    // 0/0 has no divisor: pass it through unreduced
                    if (status.g_zero) begin
                        state_next = ST_OUT;
                    end else begin
                        cmd.div_start = 1'b1;
                        state_next    = ST_DIV;
                    end
                end else begin
                    cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/fra_dpath.sv */
`timescale 1ns / 1ps

module fra_dpath (
    input  logic                             aclk,
    input  logic                             aresetn,
    // s_tdata: num_a, den_a, num_b, den_b (lowest bits first)
    input  logic [fra_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: command
    input  logic [fra_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: result_num, result_den, zero pad (lowest bits first)
    output logic [fra_pkg::M_TDATA_W-1:0]    m_tdata,
    // m_tuser: negative
    output logic                             m_tuser,
    input  fra_pkg::cmd_t                    cmd,
    output fra_pkg::status_t                 status
);
    import fra_pkg::*;

    op_t               op_reg;
    logic [OP_W-1:0]   na_reg, da_reg, nb_reg, db_reg;
    logic [PROD_W-1:0] p0_reg, p1_reg, pd_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  u_reg, v_reg;
    logic [K_W-1:0]    k_reg;
    logic [NUM_W-1:0]  qn_reg, qd_reg;
    logic [NUM_W:0]    rn_reg, rd_reg;
    logic [NUM_W-1:0]  g_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              m_tuser_reg;

    // shared multiplier
    logic [OP_W-1:0]   mul_a, mul_b;
    logic [PROD_W-1:0] prod;

    always_comb begin
        case (cmd.mul_sel)
            SEL_P0: begin
                mul_a = na_reg;
                mul_b = (op_reg == OP_MUL) ? nb_reg : db_reg;
            end
            SEL_P1: begin
                mul_a = nb_reg;
                mul_b = da_reg;
            end
            SEL_DEN: begin
                mul_a = da_reg;
                mul_b = (op_reg == OP_DIV) ? nb_reg : db_reg;
            end
            default: begin
                mul_a = da_reg;
                mul_b = db_reg;
            end
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

    // numerator from the registered products
    logic [NUM_W-1:0] ext0, ext1, comb_num;
    logic             comb_neg;

    assign ext0 = {1'b0, p0_reg};
    assign ext1 = {1'b0, p1_reg};

    always_comb begin
        comb_neg = 1'b0;
        case (op_reg)
            OP_ADD: comb_num = ext0 + ext1;
            OP_SUB: begin
                comb_neg = (p0_reg < p1_reg);
                comb_num = comb_neg ? (ext1 - ext0) : (ext0 - ext1);
            end
            default: comb_num = ext0;
        endcase
    end

    // binary gcd step
    logic [NUM_W-1:0] u_minus_v, v_minus_u;
    logic             u_ge_v;

    assign u_ge_v    = (u_reg >= v_reg);
    assign u_minus_v = u_reg - v_reg;
    assign v_minus_u = v_reg - u_reg;

    // restoring divider step, both parts by the same gcd
    logic [NUM_W:0] g_ext, tn, td;
    logic           ge_n, ge_d;

    assign g_ext = {1'b0, g_reg};
    assign tn    = {rn_reg[NUM_W-1:0], qn_reg[NUM_W-1]};
    assign td    = {rd_reg[NUM_W-1:0], qd_reg[NUM_W-1]};
    assign ge_n  = (tn >= g_ext);
    assign ge_d  = (td >= g_ext);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= op_t'(s_tuser);
            na_reg <= s_tdata[OP_W-1:0];
            da_reg <= s_tdata[2*OP_W-1:OP_W];
            nb_reg <= s_tdata[3*OP_W-1:2*OP_W];
            db_reg <= s_tdata[4*OP_W-1:3*OP_W];
        end

        if (cmd.mul_en) begin
            case (cmd.mul_sel)
                SEL_P0:  p0_reg <= prod;
                SEL_P1:  p1_reg <= prod;
                default: pd_reg <= prod;
            endcase
        end

        if (cmd.comb) begin
            u_reg   <= comb_num;
            v_reg   <= {1'b0, pd_reg};
            qn_reg  <= comb_num;
            qd_reg  <= {1'b0, pd_reg};
            k_reg   <= '0;
            neg_reg <= comb_neg;
        end else if (cmd.gcd_step) begin
            if (!u_reg[0] && !v_reg[0]) begin
                u_reg <= u_reg >> 1;
                v_reg <= v_reg >> 1;
                k_reg <= k_reg + 1'b1;
            end else if (!u_reg[0]) begin
                u_reg <= u_reg >> 1;
            end else if (!v_reg[0]) begin
                v_reg <= v_reg >> 1;
            end else if (u_ge_v) begin
                // difference of two odd values is even
                u_reg <= u_minus_v >> 1;
            end else begin
                v_reg <= v_minus_u >> 1;
            end
        end else if (cmd.div_step) begin
            rn_reg <= ge_n ? (tn - g_ext) : tn;
            rd_reg <= ge_d ? (td - g_ext) : td;
            qn_reg <= {qn_reg[NUM_W-2:0], ge_n};
            qd_reg <= {qd_reg[NUM_W-2:0], ge_d};
        end

        if (cmd.div_start) begin
            g_reg  <= (u_reg | v_reg) << k_reg;
            rn_reg <= '0;
            rd_reg <= '0;
        end

        if (cmd.out_load) begin
            m_tdata_reg <= {{M_PAD_W{1'b0}}, qd_reg[DEN_W-1:0], qn_reg};
            m_tuser_reg <= neg_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cmd.div_start) begin
                cnt_reg <= '0;
            end else if (cmd.div_step) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    assign status.gcd_done = (u_reg == '0) || (v_reg == '0);
    assign status.g_zero   = ((u_reg | v_reg) == '0);
    assign status.div_done = (cnt_reg == CNT_W'(NUM_W));
    assign status.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hdl/fraction_arith_reduce.sv */
`timescale 1ns / 1ps
// Channel  Dir  Payload
// s_       in   tdata: num_a, den_a, num_b, den_b; tuser: command
// m_       out  tdata: result_num, result_den; tuser: negative
//
// One transaction at a time: an accept step, three multiply steps and a combine step,
// then one binary gcd step per cycle until one operand is zero, then 33 divider
// steps (skipped when the result is 0/0) and an output step.
// aresetn is synchronous, active low; it clears the controller and m_tvalid.
// A finished result waits in the output register while s_tready accepts
// the next transaction; a stalled m_tready holds the block only at the output step.

module fraction_arith_reduce (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // num_a, den_a, num_b, den_b (lowest bits first)
    input  logic [fra_pkg::S_TDATA_W-1:0]    s_tdata,
    // command
    input  logic [fra_pkg::CMD_W-1:0]        s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // result_num, result_den, zero pad (lowest bits first)
    output logic [fra_pkg::M_TDATA_W-1:0]    m_tdata,
    // negative
    output logic                             m_tuser
);
    import fra_pkg::*;

    cmd_t    cmd;
    status_t status;

    fra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    fra_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .status   (status)
    );

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
    import fra_pkg::*;

    localparam int N_RANDOM   = 1600;
    localparam int STALL_MAX  = 3000;   // cycles with no transaction before giving up
    localparam int DRAIN_WAIT = 200;

    typedef struct {
        op_t              op;
        logic [OP_W-1:0]  na;
        logic [OP_W-1:0]  da;
        logic [OP_W-1:0]  nb;
        logic [OP_W-1:0]  db;
    } frac_pair_t;

    typedef struct {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             neg;
    } frac_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [CMD_W-1:0]     s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    frac_pair_t   pair_q[$];
    frac_result_t reduced_q[$];
    int           n_total;
    int           n_loaded = 0;
    int           errors = 0;
    int           quiet_cycles = 0;
    logic         s_taken = 1'b0;
    int           src_idle_pct = 28;
    int           dst_idle_pct = 52;

    fraction_arith_reduce dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Reduced fraction of the requested operation; gcd by Euclid on 64-bit values.
    function automatic frac_result_t reduce_fraction(frac_pair_t p);
        longint unsigned na, da, nb, db, left, right, rn, rd, x, y, r;
        frac_result_t    res;
        na = p.na;
        da = p.da;
        nb = p.nb;
        db = p.db;
        res.neg = 1'b0;
        case (p.op)
            OP_ADD: begin
                rn = na * db + nb * da;
                rd = da * db;
            end
            OP_SUB: begin
                left  = na * db;
                right = nb * da;
                rd    = da * db;
                if (left >= right) begin
                    rn = left - right;
                end else begin
                    rn = right - left;
                    res.neg = 1'b1;
                end
            end
            OP_MUL: begin
                rn = na * nb;
                rd = da * db;
            end
            default: begin
                rn = na * db;
                rd = da * nb;
            end
        endcase
        x = rn;
        y = rd;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        if (x != 0) begin
            rn = rn / x;
            rd = rd / x;
        end
        res.num = rn[NUM_W-1:0];
        res.den = rd[DEN_W-1:0];
        return res;
    endfunction

    function automatic logic [OP_W-1:0] rand_operand();
        logic [OP_W-1:0] v;
        case ($urandom_range(9))
            0, 1, 2: v = OP_W'($urandom_range(1, 65535));
            3, 4:    v = OP_W'($urandom_range(1, 16));
            5:       v = 16'(1) << $urandom_range(15);
            6:       v = 16'(65535 - $urandom_range(15));
            7:       v = 16'($urandom_range(1, 255) * $urandom_range(1, 255));
            8:       v = 16'($urandom_range(1, 31) * 6 * $urandom_range(1, 300));
            default: v = OP_W'($urandom_range(1, 4095));
        endcase
        if (v == 0)
            v = OP_W'(1);
        // an occasional zero operand exercises the divide-by-zero paths
        if ($urandom_range(199) == 0)
            v = '0;
        return v;
    endfunction

    task automatic add_pair(op_t op, int na, int da, int nb, int db);
        frac_pair_t p;
        p.op = op;
        p.na = OP_W'(na);
        p.da = OP_W'(da);
        p.nb = OP_W'(nb);
        p.db = OP_W'(db);
        pair_q.push_back(p);
    endtask

    task automatic add_random_pair();
        frac_pair_t p;
        int         k;
        p.op = op_t'($urandom_range(3));
        p.na = rand_operand();
        p.da = rand_operand();
        case ($urandom_range(7))
            0: begin
                // same value scaled: sums double, differences vanish, quotients are 1
                k = $urandom_range(1, 8);
                if (p.na > 16'hFFFF / k || p.da > 16'hFFFF / k)
                    k = 1;
                p.nb = OP_W'(p.na * k);
                p.db = OP_W'(p.da * k);
            end
            1: begin
                // shared factors between the operands
                k = $urandom_range(2, 64);
                p.na = OP_W'(k * $urandom_range(1, 1000));
                p.db = OP_W'(k * $urandom_range(1, 1000));
                p.nb = OP_W'(k * $urandom_range(1, 1000));
                p.da = OP_W'(k * $urandom_range(1, 1000));
            end
            default: begin
                p.nb = rand_operand();
                p.db = rand_operand();
            end
        endcase
        pair_q.push_back(p);
    endtask

    initial begin
        add_pair(OP_ADD, 1, 1, 1, 1);
        add_pair(OP_SUB, 1, 1, 1, 1);
        add_pair(OP_MUL, 1, 1, 1, 1);
        add_pair(OP_DIV, 1, 1, 1, 1);
        add_pair(OP_ADD, 65535, 1, 65535, 1);
        add_pair(OP_ADD, 65535, 65534, 65533, 65535);
        add_pair(OP_SUB, 1, 65535, 65535, 1);
        add_pair(OP_SUB, 65535, 1, 1, 65535);
        add_pair(OP_SUB, 1, 3, 1, 2);
        add_pair(OP_SUB, 2, 4, 1, 2);
        add_pair(OP_MUL, 65535, 1, 65535, 1);
        add_pair(OP_MUL, 1, 65535, 1, 65535);
        add_pair(OP_DIV, 65535, 1, 1, 65535);
        add_pair(OP_DIV, 1, 65535, 65535, 1);
        add_pair(OP_DIV, 12, 18, 8, 27);
        add_pair(OP_ADD, 32768, 21845, 43690, 16384);
        // zero numerator, zero denominator and 0/0
        add_pair(OP_MUL, 0, 7, 3, 5);
        add_pair(OP_ADD, 3, 0, 5, 7);
        add_pair(OP_DIV, 3, 7, 0, 5);
        add_pair(OP_MUL, 0, 0, 3, 5);
        add_pair(OP_SUB, 0, 0, 0, 0);
        add_pair(OP_DIV, 0, 4, 0, 9);
        repeat (N_RANDOM)
            add_random_pair();
        n_total = pair_q.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pair_q.size() != 0 || s_tvalid || reduced_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // driver: new values at the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (n_loaded >= 2 * n_total / 3) begin
                src_idle_pct = 0;
                dst_idle_pct = 0;
            end else if (n_loaded >= n_total / 3) begin
                src_idle_pct = 52;
                dst_idle_pct = 28;
            end
            if (!s_tvalid || s_taken) begin
                if (pair_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    frac_pair_t p;
                    p = pair_q.pop_front();
                    s_tdata  <= {p.db, p.nb, p.da, p.na};
                    s_tuser  <= p.op;
                    s_tvalid <= 1'b1;
                    n_loaded <= n_loaded + 1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= dst_idle_pct);
        end
    end

    // input capture and result check at the rising edge
    always @(posedge aclk) begin : monitor
        frac_pair_t   p;
        frac_result_t want;
        logic [NUM_W-1:0] got_num;
        logic [DEN_W-1:0] got_den;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            p.op = op_t'(s_tuser);
            p.na = s_tdata[0*OP_W +: OP_W];
            p.da = s_tdata[1*OP_W +: OP_W];
            p.nb = s_tdata[2*OP_W +: OP_W];
            p.db = s_tdata[3*OP_W +: OP_W];
            reduced_q.push_back(reduce_fraction(p));
        end
        if (aresetn && m_tvalid && m_tready) begin
            got_num = m_tdata[NUM_W-1:0];
            got_den = m_tdata[NUM_W +: DEN_W];
            if (reduced_q.size() == 0) begin
                $error("unexpected result transaction: num=%0d den=%0d neg=%0b",
                       got_num, got_den, m_tuser);
                errors++;
            end else begin
                want = reduced_q.pop_front();
                if (got_num !== want.num) begin
                    $error("result_num: expected %0d, got %0d", want.num, got_num);
                    errors++;
                end
                if (got_den !== want.den) begin
                    $error("result_den: expected %0d, got %0d", want.den, got_den);
                    errors++;
                end
                if (m_tuser !== want.neg) begin
                    $error("negative: expected %0b, got %0b", want.neg, m_tuser);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
